// ===== rtl/vlcs_pkg.sv =====
// Shared types, widths and codes for the versioned log cursor seek block.
package vlcs_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W    = IDX_W + 1;
  localparam int unsigned VER_W    = 64;
  localparam int unsigned HND_W    = 32;
  localparam int unsigned POS_W    = 10;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_NEXT   = 2'd1;
  localparam logic [1:0] OP_SEEK   = 2'd2;
  localparam logic [1:0] OP_RESET  = 2'd3;

  localparam logic [2:0] STS_OK   = 3'd0;
  localparam logic [2:0] STS_END  = 3'd1;
  localparam logic [2:0] STS_DECR = 3'd2;
  localparam logic [2:0] STS_FULL = 3'd3;
  localparam logic [2:0] STS_ZERO = 3'd4;

  typedef struct packed {
    logic [1:0]       operation;
    logic [VER_W-1:0] version;
    logic [HND_W-1:0] entry_handle;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             cursor_valid;
    logic [POS_W-1:0] position;
    logic [VER_W-1:0] current_version;
    logic [HND_W-1:0] current_handle;
  } out_beat_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [VER_W-1:0] version;
    logic [HND_W-1:0] handle;
  } mem_wr_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

// ===== rtl/vlcs_log_ram.sv =====
// Log storage: version and handle columns, one write port, one registered read port.
module vlcs_log_ram
  import vlcs_pkg::*;
(
  input  logic             clk_i,
  input  mem_wr_t          wr_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [VER_W-1:0] rd_version_o,
  output logic [HND_W-1:0] rd_handle_o
);

  logic [VER_W+HND_W-1:0] mem_q [CAPACITY];
  logic [VER_W+HND_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= {wr_i.version, wr_i.handle};
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rd_version_o = rdata_q[VER_W+HND_W-1:HND_W];
  assign rd_handle_o  = rdata_q[HND_W-1:0];

endmodule

// ===== rtl/vlcs_cmp.sv =====
// Shared 64-bit magnitude comparator used by append, range check and bisection.
module vlcs_cmp
  import vlcs_pkg::*;
(
  input  logic [VER_W-1:0] a_i,
  input  logic [VER_W-1:0] b_i,
  output cmp_res_t         res_o
);

  assign res_o.eq = (a_i == b_i);
  assign res_o.lt = (a_i < b_i);

endmodule

// ===== rtl/versioned_log_cursor_seek_top.sv =====
// Append-only version log with a bisection-seek cursor (top level).
// Append, next and reset cursor: the result passes the EXEC, RD and RESP states; a new beat is taken only in IDLE.
// Seek: probes the first entry, then the last, then bisects; at most log2(CAPACITY)+2 probes.
// One item at a time; the log RAM's single read port and the shared comparator set the pace.
// Reset clears entry count, last version and cursor; RAM contents are not cleared.
// The result register lets the output wait for ready while the next item is accepted.
module versioned_log_cursor_seek_top
  import vlcs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SEEK = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_LAST  = 2'd1;
  localparam logic [1:0] PH_MID   = 2'd2;

  logic [2:0]       state_q, state_d;
  logic [1:0]       phase_q, phase_d;
  logic [1:0]       op_q, op_d;
  logic [VER_W-1:0] ver_q, ver_d;
  logic [HND_W-1:0] hnd_q, hnd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [VER_W-1:0] last_q, last_d;
  logic             started_q, started_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] lo_q, lo_d;
  logic [IDX_W-1:0] hi_q, hi_d;
  logic [2:0]       status_q, status_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q, out_d;

  mem_wr_t          mem_wr;
  logic [IDX_W-1:0] raddr;
  logic [VER_W-1:0] rd_version;
  logic [HND_W-1:0] rd_handle;
  logic [VER_W-1:0] cmp_a, cmp_b;
  cmp_res_t         cmp_res;

  logic [IDX_W-1:0] mid, mid_lo, mid_hi;
  logic             span_ok, span_lo_ok, span_hi_ok;
  logic             cur_in_log;

  function automatic logic [IDX_W-1:0] mid_of(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return s[SUM_W-1:1];
  endfunction

  // Candidate probes for the next bisection step, both sides in parallel.
  assign mid        = mid_of(lo_q, hi_q);
  assign mid_lo     = mid_of(lo_q, mid);
  assign mid_hi     = mid_of(mid, hi_q);
  assign span_ok    = SUM_W'(hi_q) > (SUM_W'(lo_q) + SUM_W'(1));
  assign span_lo_ok = SUM_W'(mid) > (SUM_W'(lo_q) + SUM_W'(1));
  assign span_hi_ok = SUM_W'(hi_q) > (SUM_W'(mid) + SUM_W'(1));
  assign cur_in_log = started_q && (CNT_W'(cur_q) < cnt_q);

  vlcs_log_ram u_ram (
    .clk_i        (clk_i),
    .wr_i         (mem_wr),
    .raddr_i      (raddr),
    .rd_version_o (rd_version),
    .rd_handle_o  (rd_handle)
  );

  vlcs_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    op_d        = op_q;
    ver_d       = ver_q;
    hnd_d       = hnd_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    started_d   = started_q;
    cur_d       = cur_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_wr      = '0;
    raddr       = cur_q;
    cmp_a       = ver_q;
    cmp_b       = rd_version;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i.operation;
          ver_d   = in_data_i.version;
          hnd_d   = in_data_i.entry_handle;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = STS_OK;
        state_d  = S_RD;
        if (op_q == OP_APPEND) begin
          cmp_a = ver_q;
          cmp_b = last_q;
        end else begin
          cmp_a = last_q;
          cmp_b = ver_q;
        end
        unique case (op_q)
          OP_APPEND: begin
            if (cmp_res.lt) begin
              status_d = STS_DECR;
            end else if (cnt_q == CNT_W'(CAPACITY)) begin
              status_d = STS_FULL;
            end else begin
              mem_wr.en      = 1'b1;
              mem_wr.addr    = cnt_q[IDX_W-1:0];
              mem_wr.version = ver_q;
              mem_wr.handle  = hnd_q;
              cnt_d          = cnt_q + CNT_W'(1);
              last_d         = ver_q;
            end
          end
          OP_NEXT: begin
            if (cnt_q == '0) begin
              status_d = STS_END;
            end else if (started_q && (CNT_W'(cur_q) == cnt_q - CNT_W'(1))) begin
              status_d = STS_END;
            end else if (!started_q) begin
              started_d = 1'b1;
              cur_d     = '0;
            end else begin
              cur_d = cur_q + IDX_W'(1);
            end
          end
          OP_SEEK: begin
            if (ver_q == '0) begin
              status_d = STS_ZERO;
            end else if (cmp_res.lt || (cnt_q == '0)) begin
              status_d = STS_END;
            end else begin
              started_d = 1'b1;
              lo_d      = '0;
              hi_d      = IDX_W'(cnt_q - CNT_W'(1));
              raddr     = '0;
              phase_d   = PH_FIRST;
              state_d   = S_SEEK;
            end
          end
          OP_RESET: begin
            started_d = 1'b0;
          end
          default: ;
        endcase
      end
      S_SEEK: begin
        cmp_a = ver_q;
        cmp_b = rd_version;
        unique case (phase_q)
          PH_FIRST: begin
            // at or below the first version lands on entry 0
            if (cmp_res.eq || cmp_res.lt) begin
              cur_d   = lo_q;
              state_d = S_RD;
            end else begin
              raddr   = hi_q;
              phase_d = PH_LAST;
            end
          end
          PH_LAST: begin
            if (cmp_res.eq || !span_ok) begin
              cur_d   = hi_q;
              state_d = S_RD;
            end else begin
              raddr   = mid;
              phase_d = PH_MID;
            end
          end
          PH_MID: begin
            if (cmp_res.eq) begin
              cur_d   = mid;
              state_d = S_RD;
            end else if (cmp_res.lt) begin
              hi_d = mid;
              if (span_lo_ok) begin
                raddr = mid_lo;
              end else begin
                cur_d   = mid;
                state_d = S_RD;
              end
            end else begin
              lo_d = mid;
              if (span_hi_ok) begin
                raddr = mid_hi;
              end else begin
                cur_d   = hi_q;
                state_d = S_RD;
              end
            end
          end
          default: begin
            state_d = S_RD;
          end
        endcase
      end
      S_RD: begin
        raddr   = cur_q;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.status       = status_q;
          out_d.cursor_valid = cur_in_log;
          if (cur_in_log) begin
            out_d.position        = POS_W'(cur_q);
            out_d.current_version = rd_version;
            out_d.current_handle  = rd_handle;
          end else begin
            out_d.position        = '0;
            out_d.current_version = '0;
            out_d.current_handle  = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_FIRST;
      cnt_q       <= '0;
      last_q      <= '0;
      started_q   <= 1'b0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      started_q   <= started_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    ver_q    <= ver_d;
    hnd_q    <= hnd_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_cursor_in_log: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> (CNT_W'(cur_q) < cnt_q))
    else $error("cursor past end of log");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat taken while busy");

  a_resp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result loaded outside response state");

  a_bisect_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEEK && phase_q == PH_MID) |-> (lo_q < hi_q))
    else $error("bisection bounds crossed");

endmodule
